/* sv/swmm_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the sliding window min/max filter.
// No dependencies.
package swmm_pkg;

   localparam int RADIUS_BITS    = 5;
   localparam int FILL_BITS      = RADIUS_BITS + 1;
   localparam int GROUP_SIZE     = 8;
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 5;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_RADIUS      = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DILATE_MODE = 1'b1;

   // one window evaluation in flight
   typedef struct packed {
      logic                   mode;
      logic                   flush;
      logic                   row_last;
      logic [RADIUS_BITS-1:0] lag;
      logic [RADIUS_BITS-1:0] radius;
      logic [FILL_BITS-1:0]   fill;
   } job_type;

endpackage

/* sv/swmm_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the sample and result streams.
// No dependencies.
interface swmm_req_if #(
   parameter int SAMPLE_BITS = 16
);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] sample;
   logic                   row_end;

   modport source (output valid, output sample, output row_end, input ready);
   modport sink (input valid, input sample, input row_end, output ready);
endinterface

interface swmm_rsp_if #(
   parameter int SAMPLE_BITS = 16
);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] filtered_value;
   logic                   row_last;

   modport source (output valid, output filtered_value, output row_last, input ready);
   modport sink (input valid, input filtered_value, input row_last, output ready);
endinterface

/* sv/sliding_window_min_max_filter_unit.sv */
`timescale 1ns / 1ps
// Top level of the sliding window min/max filter (1-D dilation / erosion).
// Depends on swmm_pkg, swmm_if, swmm_seq and swmm_reduce.
//
// Takes one sample per clock while the result side is not stalled and no flush
// is running. Each sample past the first R of a row yields one result through
// the job register, partial register and result register. A sample marked
// row_end on a row of n samples yields min(n, R + 1) results, issued one per
// cycle from the stored window unless the result side stalls; no new sample is
// taken until that flush is done. The window is held in a 2*MAX_RADIUS+1 entry
// shift line and reduced by an 8-way min/max tree in two registered levels.
// Radius and mode changes apply to samples accepted after the write; radius
// values above MAX_RADIUS act as MAX_RADIUS.
module sliding_window_min_max_filter_unit import swmm_pkg::*; #(
   parameter int MAX_RADIUS = 31,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wr_data,
   swmm_req_if.sink                  req_if,
   swmm_rsp_if.source                rsp_if
);

   localparam int WIN_DEPTH = 2 * MAX_RADIUS + 1;

   logic                   req_ready, job_adv, job_valid, flush_more;
   job_type                job;
   logic [SAMPLE_BITS-1:0] store [WIN_DEPTH];
   logic                   rsp_valid, rsp_last;
   logic [SAMPLE_BITS-1:0] rsp_value;

   swmm_seq #(
      .MAX_RADIUS (MAX_RADIUS),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wr_data(csr_wr_data),
      .req_valid  (req_if.valid),
      .req_sample (req_if.sample),
      .req_row_end(req_if.row_end),
      .req_ready  (req_ready),
      .job_adv    (job_adv),
      .job_valid  (job_valid),
      .job        (job),
      .flush_more (flush_more),
      .store      (store)
   );

   swmm_reduce #(
      .MAX_RADIUS (MAX_RADIUS),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_reduce (
      .clock    (clock),
      .reset    (reset),
      .job_valid(job_valid),
      .job      (job),
      .store    (store),
      .job_adv  (job_adv),
      .rsp_ready(rsp_if.ready),
      .rsp_valid(rsp_valid),
      .rsp_value(rsp_value),
      .rsp_last (rsp_last)
   );

   assign req_if.ready          = req_ready;
   assign rsp_if.valid          = rsp_valid;
   assign rsp_if.filtered_value = rsp_value;
   assign rsp_if.row_last       = rsp_last;

   a_row_end_starts_flush: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready && req_if.row_end) |=> (job_valid && job.flush))
      else $error("row_end transaction did not start a flush");

   a_store_held_in_flush: assert property (@(posedge clock) disable iff (reset)
      flush_more |=> $stable(store[0]))
      else $error("window changed during flush");

   a_last_only_in_flush: assert property (@(posedge clock) disable iff (reset)
      (job_valid && job.row_last) |-> (job.flush && (job.lag == '0)))
      else $error("row_last outside the end of a flush");

endmodule

/* sv/swmm_seq.sv */
`timescale 1ns / 1ps
// Config registers, sample shift line, row fill count and window job sequencer.
// Depends on swmm_pkg.
module swmm_seq import swmm_pkg::*; #(
   parameter int MAX_RADIUS = 31,
   parameter int SAMPLE_BITS = 16,
   localparam int WIN_DEPTH = 2 * MAX_RADIUS + 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wr_data,
   input  logic                      req_valid,
   input  logic [SAMPLE_BITS-1:0]    req_sample,
   input  logic                      req_row_end,
   output logic                      req_ready,
   input  logic                      job_adv,
   output logic                      job_valid,
   output job_type                   job,
   output logic                      flush_more,
   output logic [SAMPLE_BITS-1:0]    store [WIN_DEPTH]
);

   localparam logic [RADIUS_BITS-1:0] RADIUS_CAP = RADIUS_BITS'(MAX_RADIUS);
   localparam logic [FILL_BITS-1:0]   FILL_CAP   = FILL_BITS'(WIN_DEPTH);

   logic [RADIUS_BITS-1:0] radius_ff, radius_ff_in, r_eff;
   logic                   mode_ff, mode_ff_in;
   logic [FILL_BITS-1:0]   fill_ff, fill_ff_in, fill_next, flush_span;
   logic                   job_valid_ff, job_valid_ff_in, new_valid, accept;
   job_type                job_ff, job_ff_in, new_job;
   logic [SAMPLE_BITS-1:0] store_ff [WIN_DEPTH];
   logic [SAMPLE_BITS-1:0] store_ff_in [WIN_DEPTH];

   always_comb begin
      radius_ff_in = radius_ff;
      mode_ff_in   = mode_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_RADIUS: begin
               radius_ff_in = csr_wr_data[RADIUS_BITS-1:0];
            end
            CSR_DILATE_MODE: begin
               mode_ff_in = csr_wr_data[0];
            end
            default: begin
               radius_ff_in = radius_ff;
            end
         endcase
      end
   end

   always_comb begin
      r_eff      = (radius_ff > RADIUS_CAP) ? RADIUS_CAP : radius_ff;
      fill_next  = (fill_ff < FILL_CAP) ? fill_ff + 1'b1 : fill_ff;
      flush_span = fill_next - 1'b1;

      new_job.mode   = mode_ff;
      new_job.flush  = req_row_end;
      new_job.radius = r_eff;
      new_job.fill   = fill_next;
      if (req_row_end) begin
         new_job.lag = (flush_span > {1'b0, r_eff}) ? r_eff
                                                     : flush_span[RADIUS_BITS-1:0];
      end else begin
         new_job.lag = r_eff;
      end
      new_job.row_last = req_row_end && (new_job.lag == '0);
      new_valid        = req_row_end || (fill_next > {1'b0, r_eff});

      flush_more = job_valid_ff && job_ff.flush && (job_ff.lag != '0);
      req_ready  = job_adv && !flush_more;
      accept     = req_valid && req_ready;

      job_valid_ff_in = job_valid_ff;
      job_ff_in       = job_ff;
      if (job_adv) begin
         if (flush_more) begin
            job_valid_ff_in    = 1'b1;
            job_ff_in.lag      = job_ff.lag - 1'b1;
            job_ff_in.row_last = (job_ff.lag == RADIUS_BITS'(1));
         end else if (accept) begin
            job_valid_ff_in = new_valid;
            job_ff_in       = new_job;
         end else begin
            job_valid_ff_in = 1'b0;
         end
      end

      fill_ff_in  = fill_ff;
      store_ff_in = store_ff;
      if (accept) begin
         fill_ff_in     = req_row_end ? '0 : fill_next;
         store_ff_in[0] = req_sample;
         for (int k = 1; k < WIN_DEPTH; k++) begin
            store_ff_in[k] = store_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff    <= '0;
         mode_ff      <= 1'b1;
         fill_ff      <= '0;
         job_valid_ff <= 1'b0;
      end else begin
         radius_ff    <= radius_ff_in;
         mode_ff      <= mode_ff_in;
         fill_ff      <= fill_ff_in;
         job_valid_ff <= job_valid_ff_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff   <= job_ff_in;
      store_ff <= store_ff_in;
   end

   assign job_valid = job_valid_ff;
   assign job       = job_ff;
   assign store     = store_ff;

endmodule

/* sv/swmm_reduce.sv */
`timescale 1ns / 1ps
// Two-level registered min/max tree over the masked window, plus result register.
// Depends on swmm_pkg.
module swmm_reduce import swmm_pkg::*; #(
   parameter int MAX_RADIUS = 31,
   parameter int SAMPLE_BITS = 16,
   localparam int WIN_DEPTH = 2 * MAX_RADIUS + 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   job_valid,
   input  job_type                job,
   input  logic [SAMPLE_BITS-1:0] store [WIN_DEPTH],
   output logic                   job_adv,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output logic [SAMPLE_BITS-1:0] rsp_value,
   output logic                   rsp_last
);

   localparam int GROUPS = (WIN_DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;

   function automatic logic [SAMPLE_BITS-1:0] pick(input logic dilate,
                                                   input logic [SAMPLE_BITS-1:0] a,
                                                   input logic [SAMPLE_BITS-1:0] b);
      if (dilate) begin
         return (a > b) ? a : b;
      end
      return (a < b) ? a : b;
   endfunction

   logic [FILL_BITS-1:0]   hi;
   logic [SAMPLE_BITS-1:0] neutral;
   logic [SAMPLE_BITS-1:0] part_ff [GROUPS];
   logic [SAMPLE_BITS-1:0] part_ff_in [GROUPS];
   logic                   part_valid_ff, part_mode_ff, part_last_ff;
   logic                   rsp_valid_ff, rsp_last_ff;
   logic [SAMPLE_BITS-1:0] rsp_value_ff, rsp_value_ff_in;
   logic                   adv_b, adv_c;

   assign adv_c   = !rsp_valid_ff || rsp_ready;
   assign adv_b   = !part_valid_ff || adv_c;
   assign job_adv = !job_valid || adv_b;

   // entries up to lag + radius that belong to the current row
   always_comb begin
      logic [SAMPLE_BITS-1:0] acc;
      hi      = FILL_BITS'(job.lag) + FILL_BITS'(job.radius);
      neutral = job.mode ? '0 : '1;
      for (int g = 0; g < GROUPS; g++) begin
         acc = neutral;
         for (int j = 0; j < GROUP_SIZE; j++) begin
            if (g * GROUP_SIZE + j < WIN_DEPTH) begin
               if ((FILL_BITS'(g * GROUP_SIZE + j) <= hi) &&
                   (FILL_BITS'(g * GROUP_SIZE + j) < job.fill)) begin
                  acc = pick(job.mode, acc, store[g * GROUP_SIZE + j]);
               end
            end
         end
         part_ff_in[g] = acc;
      end
   end

   always_comb begin
      rsp_value_ff_in = part_mode_ff ? '0 : '1;
      for (int g = 0; g < GROUPS; g++) begin
         rsp_value_ff_in = pick(part_mode_ff, rsp_value_ff_in, part_ff[g]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         part_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (adv_b) begin
            part_valid_ff <= job_valid;
         end
         if (adv_c) begin
            rsp_valid_ff <= part_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv_b) begin
         part_ff      <= part_ff_in;
         part_mode_ff <= job.mode;
         part_last_ff <= job.row_last;
      end
      if (adv_c) begin
         rsp_value_ff <= rsp_value_ff_in;
         rsp_last_ff  <= part_last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;
   assign rsp_last  = rsp_last_ff;

endmodule
